// ===== hdl/rbs_pkg.sv =====
// rbs_pkg: shared widths, saturation limits, register indexes and lane
// structs for the ray/box slab test. No dependencies.
package rbs_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int NUM_AXES    = 3;
  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
  localparam int PROD_WIDTH  = DIFF_WIDTH + COORD_WIDTH;
  localparam int CFG_IDX_W   = 3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;

  localparam coord_t POS_LIMIT = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t NEG_LIMIT = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam prod_t  POS_EXT   = PROD_WIDTH'(POS_LIMIT);
  localparam prod_t  NEG_EXT   = PROD_WIDTH'(NEG_LIMIT);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

  // stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } adv_t;

  // what one lane hands to the merge stage
  typedef struct packed {
    coord_t near_t;
    coord_t far_t;
    logic   outside;
  } lane_res_t;

  // floor(p / 2^FRAC_BITS), clamped to the coordinate range
  function automatic coord_t sat_shift(input prod_t p);
    prod_t s;
    coord_t r;
    s = p >>> FRAC_BITS;
    if (s > POS_EXT) begin
      r = POS_LIMIT;
    end else if (s < NEG_EXT) begin
      r = NEG_LIMIT;
    end else begin
      r = s[COORD_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/rbs_lane.sv =====
// rbs_lane: one axis of the slab test, three pipeline stages
// (difference, product, floor/saturate/order). Depends on rbs_pkg.
module rbs_lane (
  input  logic              clk,
  input  rbs_pkg::adv_t     adv,
  input  rbs_pkg::coord_t   box_lo,
  input  rbs_pkg::coord_t   box_hi,
  input  rbs_pkg::coord_t   origin,
  input  rbs_pkg::coord_t   inv_dir,
  input  logic              par,
  output rbs_pkg::lane_res_t res
);

  rbs_pkg::diff_t  d_lo_r, d_hi_r;
  rbs_pkg::coord_t inv_r;
  logic            par1_r, out1_r;
  rbs_pkg::prod_t  p_lo_r, p_hi_r;
  logic            par2_r, out2_r;
  rbs_pkg::lane_res_t res_r;

  rbs_pkg::coord_t t1, t2;
  rbs_pkg::lane_res_t res_nxt;

  // stage 1: exact corner - origin
  always_ff @(posedge clk) begin
    if (adv.s1) begin
      d_lo_r <= rbs_pkg::DIFF_WIDTH'(box_lo) - rbs_pkg::DIFF_WIDTH'(origin);
      d_hi_r <= rbs_pkg::DIFF_WIDTH'(box_hi) - rbs_pkg::DIFF_WIDTH'(origin);
      inv_r  <= inv_dir;
      par1_r <= par;
      out1_r <= par && ((origin < box_lo) || (origin > box_hi));
    end
  end

  // stage 2: exact products
  always_ff @(posedge clk) begin
    if (adv.s2) begin
      p_lo_r <= rbs_pkg::PROD_WIDTH'(d_lo_r) * rbs_pkg::PROD_WIDTH'(inv_r);
      p_hi_r <= rbs_pkg::PROD_WIDTH'(d_hi_r) * rbs_pkg::PROD_WIDTH'(inv_r);
      par2_r <= par1_r;
      out2_r <= out1_r;
    end
  end

  // stage 3: floor, saturate and order the two distances; a parallel axis leaves the interval open
  always_comb begin
    t1 = rbs_pkg::sat_shift(p_lo_r);
    t2 = rbs_pkg::sat_shift(p_hi_r);
    res_nxt.outside = out2_r;
    if (par2_r) begin
      res_nxt.near_t = rbs_pkg::NEG_LIMIT;
      res_nxt.far_t  = rbs_pkg::POS_LIMIT;
    end else if (t1 < t2) begin
      res_nxt.near_t = t1;
      res_nxt.far_t  = t2;
    end else begin
      res_nxt.near_t = t2;
      res_nxt.far_t  = t1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== hdl/rbs_merge.sv =====
// rbs_merge: combines the lane intervals into entry/exit distances and
// the outside flag, one registered stage. Depends on rbs_pkg.
module rbs_merge (
  input  logic               clk,
  input  logic               en,
  input  rbs_pkg::lane_res_t lane [rbs_pkg::NUM_AXES],
  output rbs_pkg::coord_t    tmin,
  output rbs_pkg::coord_t    tmax,
  output logic               outside
);

  rbs_pkg::coord_t tmin_nxt, tmax_nxt, tmin_r, tmax_r;
  logic            out_nxt, outside_r;

  always_comb begin
    tmin_nxt = rbs_pkg::NEG_LIMIT;
    tmax_nxt = rbs_pkg::POS_LIMIT;
    out_nxt  = 1'b0;
    for (int i = 0; i < rbs_pkg::NUM_AXES; i++) begin
      if (lane[i].near_t > tmin_nxt) tmin_nxt = lane[i].near_t;
      if (lane[i].far_t < tmax_nxt)  tmax_nxt = lane[i].far_t;
      out_nxt = out_nxt | lane[i].outside;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tmin_r    <= tmin_nxt;
      tmax_r    <= tmax_nxt;
      outside_r <= out_nxt;
    end
  end

  assign tmin    = tmin_r;
  assign tmax    = tmax_r;
  assign outside = outside_r;

endmodule

// ===== hdl/ray_box_slab_test.sv =====
// ray_box_slab_test: top level, box registers, three axis lanes, merge
// stage and output register. Depends on rbs_pkg, rbs_lane, rbs_merge.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | in_tdata origins and reciprocals, in_tuser mask
//  out_    | out | out_tvalid/out_tready| out_tdata entry distance, out_tuser hit
//  cfg_    | in  | cfg_we               | cfg_index, cfg_wdata
//
// One ray per cycle while the output is not stalled; one register stage each for
// difference, 33x32 product, floor/saturate/order, merge and output.
// Reset (rst_n low, synchronous) empties the pipe and zeroes the box.
// A stalled output holds only the stages behind it that are full; empty
// stages keep taking words, so in_tready drops only when every stage is full.
module ray_box_slab_test (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // from bit 0: origin_x, origin_y, origin_z, inv_dir_x, inv_dir_y, inv_dir_z
  input  logic [191:0] in_tdata,
  // from bit 0: axis_parallel[2:0]
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // from bit 0: entry_distance
  output logic [31:0]  out_tdata,
  // from bit 0: hit
  output logic         out_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);

  localparam int CW = rbs_pkg::COORD_WIDTH;
  localparam int NA = rbs_pkg::NUM_AXES;

  rbs_pkg::coord_t box_lo_r [NA];
  rbs_pkg::coord_t box_hi_r [NA];

  logic v1_r, v2_r, v3_r, v4_r, ov_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy_o;
  rbs_pkg::adv_t adv;

  rbs_pkg::lane_res_t lane_res [NA];
  rbs_pkg::coord_t    tmin, tmax;
  logic               outside;
  rbs_pkg::coord_t    dist_r;
  logic               hit_r, hit_nxt;

  // box registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NA; i++) begin
        box_lo_r[i] <= '0;
        box_hi_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        rbs_pkg::REG_BOX_MIN_X: box_lo_r[0] <= cfg_wdata;
        rbs_pkg::REG_BOX_MIN_Y: box_lo_r[1] <= cfg_wdata;
        rbs_pkg::REG_BOX_MIN_Z: box_lo_r[2] <= cfg_wdata;
        rbs_pkg::REG_BOX_MAX_X: box_hi_r[0] <= cfg_wdata;
        rbs_pkg::REG_BOX_MAX_Y: box_hi_r[1] <= cfg_wdata;
        rbs_pkg::REG_BOX_MAX_Z: box_hi_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ready chain: a stage loads when it is empty or its successor moves
  assign rdy_o = !ov_r || out_tready;
  assign rdy4  = !v4_r || rdy_o;
  assign rdy3  = !v3_r || rdy4;
  assign rdy2  = !v2_r || rdy3;
  assign rdy1  = !v1_r || rdy2;
  assign in_tready = rdy1;

  assign adv.s1 = rdy1;
  assign adv.s2 = rdy2;
  assign adv.s3 = rdy3;
  assign adv.s4 = rdy4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (rdy1)  v1_r <= in_tvalid;
      if (rdy2)  v2_r <= v1_r;
      if (rdy3)  v3_r <= v2_r;
      if (rdy4)  v4_r <= v3_r;
      if (rdy_o) ov_r <= v4_r;
    end
  end

  for (genvar g = 0; g < NA; g++) begin : g_lane
    rbs_lane u_lane (
      .clk     (clk),
      .adv     (adv),
      .box_lo  (box_lo_r[g]),
      .box_hi  (box_hi_r[g]),
      .origin  (in_tdata[g*CW +: CW]),
      .inv_dir (in_tdata[(NA+g)*CW +: CW]),
      .par     (in_tuser[g]),
      .res     (lane_res[g])
    );
  end

  rbs_merge u_merge (
    .clk     (clk),
    .en      (adv.s4),
    .lane    (lane_res),
    .tmin    (tmin),
    .tmax    (tmax),
    .outside (outside)
  );

  assign hit_nxt = !outside && (tmax > rbs_pkg::coord_t'(0)) && (tmax > tmin);

  always_ff @(posedge clk) begin
    if (rdy_o) begin
      hit_r  <= hit_nxt;
      dist_r <= tmin;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = dist_r;
  assign out_tuser  = hit_r;

  // a hit needs exit > entry, so entry can never be plus infinity
  a_hit_entry_finite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata != rbs_pkg::POS_LIMIT))
    else $error("hit with entry distance at plus infinity");

  // input back-pressure only comes from a full pipe behind a stalled output
  a_stall_origin: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready && v1_r && v2_r && v3_r && v4_r))
    else $error("in_tready low with a free stage");

  // a result appears only out of a full merge stage
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(v4_r))
    else $error("result without a merged word behind it");

endmodule
